// ----- rtl/lct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lct_pkg: shared types and constants of the line coverage tracker
// Map geometry, field widths, command codes, register indexes and states.
// ----------------------------------------------------------------------------
package lct_pkg;

    // Map geometry.
    localparam int MAX_LINES     = 4096;
    localparam int MAX_UNCOVERED = 32;
    localparam int ADDR_W        = $clog2(MAX_LINES);
    localparam int UCNT_W        = $clog2(MAX_UNCOVERED + 1);

    // Fixed field widths.
    localparam int LINE_W  = 12;
    localparam int CHUNK_W = 8;
    localparam int COUNT_W = 12;
    localparam int CFG_W   = 8;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [LINE_W-1:0]  t_line;
    typedef logic [CHUNK_W-1:0] t_chunk;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [UCNT_W-1:0]  t_ucnt;

    localparam t_addr  LAST_ADDR = t_addr'(MAX_LINES - 1);
    localparam t_count COUNT_MAX = '1;
    localparam t_ucnt  UCNT_MAX  = t_ucnt'(MAX_UNCOVERED);

    // Commands carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_LINE   = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_TRACK  = 1'b0,
        CFG_TARGET = 1'b1
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SUMM
    } t_state;

    // True when a line has a place in the maps.
    function automatic logic line_in_map(t_line l);
        return (32'(l) < MAX_LINES);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/line_coverage_tracker_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_coverage_tracker_core: executed / executable line map tracker
// Records executed and executable source lines in two bit maps and walks them
// on request to report uncovered lines and the coverage counts.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------
//  s        | in        | tvalid / tready    | tuser cmd; tdata chunk_id, line
//  m        | out       | tvalid / tready    | tuser is_summary; tdata counts;
//           |           |                    | tlast ends a report
//  cfg      | in        | write enable only  | index, data (no read-back)
//
// Line events, executable marks and clears are taken while the block is idle;
// a clear then starts a sweep that clears all MAX_LINES lines of both maps.
// A report walks lines 1 to MAX_LINES-1, each in a RAM read state (S_SCAN)
// and then an evaluation state (S_EVAL), and ends in the summary (S_SUMM);
// the sequencer does not overlap the registered RAM read with the evaluation
// of the previous line. With no target chunk a report is a bare summary.
// After reset both maps are cleared by the same sweep, during which no input
// beat is taken. A stalled output holds the report walk at the line that is
// waiting to be emitted, and holds the summary until the output is free; a
// finished summary may still wait while the next input beat is taken.
// ----------------------------------------------------------------------------
module line_coverage_tracker_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [7:0] chunk_id, [19:8] line_number, [23:20] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] cmd

    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata,   // [11:0] uncovered_line, [23:12] executable_count,
                                          // [35:24] touched_count, [39:36] zero
    output logic             o_m_tuser,   // [0] is_summary
    output logic             o_m_tlast,   // last

    // Configuration writes.
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    lct_pkg::t_state r_state, n_state;
    lct_pkg::t_addr  r_addr,  n_addr;    // sweep / scan line address
    lct_pkg::t_count r_ex,    n_ex;      // executable lines seen in this report
    lct_pkg::t_count r_tc,    n_tc;      // executed lines among them
    lct_pkg::t_ucnt  r_n,     n_n;       // uncovered entries emitted so far

    logic            r_track;
    lct_pkg::t_chunk r_target;
    logic            r_last_valid, n_last_valid;
    lct_pkg::t_line  r_last_line,  n_last_line;

    // Output register.
    logic            r_out_valid, n_out_valid;
    logic            r_out_summ,  n_out_summ;
    lct_pkg::t_line  r_out_line,  n_out_line;
    lct_pkg::t_count r_out_ex,    n_out_ex;
    lct_pkg::t_count r_out_tc,    n_out_tc;

    // ------------------------------------------------------------------
    // Input beat decode
    // ------------------------------------------------------------------
    lct_pkg::t_cmd   in_cmd;
    lct_pkg::t_chunk in_chunk;
    lct_pkg::t_line  in_line;
    logic            in_accept;
    logic            line_hit;       // line event that gets recorded
    logic            out_free;       // output register can take a new beat

    assign in_cmd    = lct_pkg::t_cmd'(i_s_tuser);
    assign in_chunk  = i_s_tdata[7:0];
    assign in_line   = i_s_tdata[19:8];
    assign in_accept = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;

    // A repeated line, line zero, another chunk or tracking off all skip the
    // event. A line beyond the map still becomes the last recorded line.
    assign line_hit = r_track && (in_chunk == r_target) && (in_line != '0)
                      && !(r_last_valid && (in_line == r_last_line));

    // ------------------------------------------------------------------
    // Map RAMs: one for executed lines, one for executable lines
    // ------------------------------------------------------------------
    logic           exd_we, exe_we;
    lct_pkg::t_addr wr_addr;
    logic           wr_bit;
    logic           exd_rdata, exe_rdata;

    lct_ram #(
        .WIDTH (1),
        .DEPTH (lct_pkg::MAX_LINES)
    ) u_executed_ram (
        .i_clk   (i_clk),
        .i_we    (exd_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_bit),
        .i_raddr (r_addr),
        .o_rdata (exd_rdata)
    );

    lct_ram #(
        .WIDTH (1),
        .DEPTH (lct_pkg::MAX_LINES)
    ) u_executable_ram (
        .i_clk   (i_clk),
        .i_we    (exe_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_bit),
        .i_raddr (r_addr),
        .o_rdata (exe_rdata)
    );

    // Evaluation of the line read in the previous cycle.
    logic eval_emit;     // executable, never executed and room left
    logic eval_stall;    // emission pending but the output is still full

    assign eval_emit  = exe_rdata && !exd_rdata && (r_n < lct_pkg::UCNT_MAX);
    assign eval_stall = eval_emit && !out_free;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lct_pkg::S_CLEAR: begin
                if (r_addr == lct_pkg::LAST_ADDR) begin
                    n_state = lct_pkg::S_IDLE;
                end
            end
            lct_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (in_cmd)
                        lct_pkg::CMD_CLEAR: n_state = lct_pkg::S_CLEAR;
                        lct_pkg::CMD_REPORT: begin
                            // With no target chunk the report is a bare summary.
                            if (r_target == '0) begin
                                n_state = lct_pkg::S_SUMM;
                            end else begin
                                n_state = lct_pkg::S_SCAN;
                            end
                        end
                        default: n_state = lct_pkg::S_IDLE;
                    endcase
                end
            end
            lct_pkg::S_SCAN: n_state = lct_pkg::S_EVAL;
            lct_pkg::S_EVAL: begin
                if (!eval_stall) begin
                    if (r_addr == lct_pkg::LAST_ADDR) begin
                        n_state = lct_pkg::S_SUMM;
                    end else begin
                        n_state = lct_pkg::S_SCAN;
                    end
                end
            end
            lct_pkg::S_SUMM: begin
                if (out_free) begin
                    n_state = lct_pkg::S_IDLE;
                end
            end
            default: n_state = lct_pkg::S_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and output logic
    // ------------------------------------------------------------------
    always_comb begin
        o_s_tready   = (r_state == lct_pkg::S_IDLE);
        n_addr       = r_addr;
        n_ex         = r_ex;
        n_tc         = r_tc;
        n_n          = r_n;
        n_last_valid = r_last_valid;
        n_last_line  = r_last_line;
        exd_we       = 1'b0;
        exe_we       = 1'b0;
        wr_addr      = lct_pkg::t_addr'(in_line);
        wr_bit       = 1'b1;

        // A taken output beat empties the register unless reloaded below.
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_summ  = r_out_summ;
        n_out_line  = r_out_line;
        n_out_ex    = r_out_ex;
        n_out_tc    = r_out_tc;

        case (r_state)
            lct_pkg::S_CLEAR: begin
                exd_we  = 1'b1;
                exe_we  = 1'b1;
                wr_addr = r_addr;
                wr_bit  = 1'b0;
                if (r_addr != lct_pkg::LAST_ADDR) begin
                    n_addr = r_addr + 1'b1;
                end
            end
            lct_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (in_cmd)
                        lct_pkg::CMD_LINE: begin
                            if (line_hit) begin
                                exd_we       = lct_pkg::line_in_map(in_line);
                                n_last_valid = 1'b1;
                                n_last_line  = in_line;
                            end
                        end
                        lct_pkg::CMD_MARK: begin
                            exe_we = (in_line != '0) && lct_pkg::line_in_map(in_line);
                        end
                        lct_pkg::CMD_REPORT: begin
                            n_addr = lct_pkg::t_addr'(1);
                            n_ex   = '0;
                            n_tc   = '0;
                            n_n    = '0;
                        end
                        lct_pkg::CMD_CLEAR: begin
                            n_addr = '0;
                        end
                        default: n_addr = r_addr;
                    endcase
                end
            end
            lct_pkg::S_EVAL: begin
                if (!eval_stall) begin
                    if (exe_rdata) begin
                        if (r_ex != lct_pkg::COUNT_MAX) begin
                            n_ex = r_ex + 1'b1;
                        end
                        if (exd_rdata && (r_tc != lct_pkg::COUNT_MAX)) begin
                            n_tc = r_tc + 1'b1;
                        end
                    end
                    if (eval_emit) begin
                        n_n         = r_n + 1'b1;
                        n_out_valid = 1'b1;
                        n_out_summ  = 1'b0;
                        n_out_line  = lct_pkg::t_line'(r_addr);
                        n_out_ex    = '0;
                        n_out_tc    = '0;
                    end
                    if (r_addr != lct_pkg::LAST_ADDR) begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            lct_pkg::S_SUMM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_summ  = 1'b1;
                    n_out_line  = '0;
                    n_out_ex    = r_ex;
                    n_out_tc    = r_tc;
                end
            end
            default: n_addr = r_addr;
        endcase

        // Writing either register forgets the last recorded line.
        if (i_cfg_we) begin
            n_last_valid = 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_summ;
    assign o_m_tlast  = r_out_summ;     // the summary always closes a report
    assign o_m_tdata  = {4'b0000, r_out_tc, r_out_ex, r_out_line};

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lct_pkg::S_CLEAR;
            r_addr       <= '0;
            r_out_valid  <= 1'b0;
            r_track      <= 1'b0;
            r_target     <= '0;
            r_last_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_out_valid  <= n_out_valid;
            r_last_valid <= n_last_valid;
            if (i_cfg_we) begin
                case (lct_pkg::t_cfg_idx'(i_cfg_addr))
                    lct_pkg::CFG_TRACK: begin
                        r_track  <= i_cfg_wdata[0];
                    end
                    lct_pkg::CFG_TARGET: begin
                        r_target <= i_cfg_wdata;
                    end
                    default: r_track <= r_track;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex        <= n_ex;
        r_tc        <= n_tc;
        r_n         <= n_n;
        r_last_line <= n_last_line;
        r_out_summ  <= n_out_summ;
        r_out_line  <= n_out_line;
        r_out_ex    <= n_out_ex;
        r_out_tc    <= n_out_tc;
    end

endmodule
`default_nettype wire

// ----- rtl/lct_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lct_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- tb/line_coverage_tracker_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_coverage_tracker_core_tb: self-checking bench of the line coverage core
// Drives line events, executable marks, clears and reports under several
// register settings. A scoreboard class keeps its own copy of both line maps
// and predicts every report beat, then checks each beat the core emits.
// ----------------------------------------------------------------------------
module line_coverage_tracker_core_tb;
    import lct_pkg::*;

    // Cycles without any beat on either stream before the run is declared hung.
    // A report walk with no uncovered lines emits no beat until its summary, and
    // the long receiver hold-off can sit on top of that.
    localparam int STALL_LIMIT = 60000;
    // Length of the one long receiver hold-off.
    localparam int HOLD_OFF    = 3000;
    // Quiet time before a register write: covers a clear sweep in flight.
    localparam int SETTLE_CYC  = MAX_LINES + 64;

    // One beat of a report, fields in the order the monitor samples them.
    typedef struct packed {
        logic   summary;
        t_line  uncovered;
        t_count executable;
        t_count touched;
        logic   ends_report;
    } t_report_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors both maps, the last recorded line and the registers,
    // and holds the report beats that are still due from the core.
    // ------------------------------------------------------------------------
    class line_map_model;
        bit [MAX_LINES-1:0] ran_lines;
        bit [MAX_LINES-1:0] exec_lines;
        bit                 prev_valid;
        t_line              prev_line;
        bit                 track_on;
        t_chunk             target;
        t_report_beat       due_beats[$];
        int                 failures;
        int                 beats_seen;

        function void write_reg(t_cfg_idx idx, logic [7:0] value);
            case (idx)
                CFG_TRACK:  track_on = value[0];
                CFG_TARGET: target   = value;
                default:    ;
            endcase
            // Any register write forgets the last recorded line.
            prev_valid = 1'b0;
        endfunction

        // Notes one accepted input beat and queues the beats it will cause.
        function void take_item(t_cmd cmd, t_chunk chunk, t_line line_no);
            int     l;
            int     listed;
            t_count exec_cnt;
            t_count hit_cnt;
            listed   = 0;
            exec_cnt = '0;
            hit_cnt  = '0;
            case (cmd)
                CMD_LINE: begin
                    if (!track_on || chunk != target) return;
                    if (prev_valid && line_no == prev_line) return;
                    if (line_no == '0) return;
                    if (32'(line_no) < MAX_LINES) ran_lines[line_no] = 1'b1;
                    prev_line  = line_no;
                    prev_valid = 1'b1;
                end
                CMD_MARK: begin
                    if (line_no != '0 && 32'(line_no) < MAX_LINES)
                        exec_lines[line_no] = 1'b1;
                end
                CMD_CLEAR: begin
                    // The last-line memory survives a clear.
                    ran_lines  = '0;
                    exec_lines = '0;
                end
                CMD_REPORT: begin
                    if (target == '0) begin
                        due_beats.push_back('{1'b1, '0, '0, '0, 1'b1});
                        return;
                    end
                    for (l = 1; l < MAX_LINES; l++) begin
                        if (!exec_lines[l]) continue;
                        if (exec_cnt != COUNT_MAX) exec_cnt++;
                        if (ran_lines[l]) begin
                            if (hit_cnt != COUNT_MAX) hit_cnt++;
                        end else if (listed < MAX_UNCOVERED) begin
                            due_beats.push_back('{1'b0, t_line'(l), '0, '0, 1'b0});
                            listed++;
                        end
                    end
                    due_beats.push_back('{1'b1, '0, exec_cnt, hit_cnt, 1'b1});
                end
                default: ;
            endcase
        endfunction

        // Compares one accepted output beat with the oldest due beat.
        function void check_beat(t_report_beat got);
            t_report_beat want;
            beats_seen++;
            if (due_beats.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected beat: summary=%0d line=%0d exec=%0d hit=%0d last=%0d",
                             got.summary, got.uncovered, got.executable, got.touched,
                             got.ends_report);
                return;
            end
            want = due_beats.pop_front();
            if (got.summary !== want.summary || got.uncovered !== want.uncovered ||
                got.executable !== want.executable || got.touched !== want.touched ||
                got.ends_report !== want.ends_report) begin
                failures++;
                if (failures <= 10) begin
                    $display("beat %0d mismatch: expected summary=%0d line=%0d exec=%0d hit=%0d last=%0d",
                             beats_seen, want.summary, want.uncovered, want.executable,
                             want.touched, want.ends_report);
                    $display("beat %0d mismatch: got summary=%0d line=%0d exec=%0d hit=%0d last=%0d",
                             beats_seen, got.summary, got.uncovered, got.executable,
                             got.touched, got.ends_report);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Everything the bench drives has a known value from time zero.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // [7:0] chunk_id, [19:8] line_number, [23:20] zero
    logic [1:0]  s_tuser   = '0;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;           // [11:0] uncovered_line, [23:12] executable_count,
                                    // [35:24] touched_count, [39:36] zero
    logic        m_tuser;           // [0] is_summary
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;

    line_map_model cov_model;
    int            stall_cycles;
    int            burst_left;
    t_line         recent_line;

    line_coverage_tracker_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor and watchdog. Both streams are sampled at the rising edge; the
    // bench only changes inputs at the falling edge, so nothing here races.
    // Output beats are checked before the input beat of the same edge is
    // noted: a beat leaving in that cycle can never belong to that input.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            cov_model.check_beat('{m_tuser, m_tdata[11:0], m_tdata[23:12],
                                   m_tdata[35:24], m_tlast});
        if (rst_n && s_tvalid && s_tready)
            cov_model.take_item(t_cmd'(s_tuser), s_tdata[7:0], s_tdata[19:8]);

        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver pacing. Runs of random length each follow one pattern: always
    // ready, coin-flip ready, ready one cycle in four, or mostly ready. Once
    // some forty beats have come through and the sender is offering, the
    // receiver holds off for a long stretch while the sender keeps offering,
    // so the core backs up and drops its input ready.
    // ------------------------------------------------------------------------
    initial begin : rx_pacing
        int mode;
        int span;
        int tick;
        bit held;
        held = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 256);
            repeat (span) begin
                @(negedge clk);
                if (!held && cov_model.beats_seen >= 40 && s_tvalid) begin
                    held = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF) @(negedge clk);
                end
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Items go out in bursts of random length; between bursts the
    // valid may drop for a random gap. Long bursts give stretches with no idling.
    // Each call starts and ends at a falling edge, and valid is assigned at
    // most once per edge.
    // ------------------------------------------------------------------------
    task automatic offer_item(input t_cmd cmd, input t_chunk chunk, input t_line line_no);
        int gap;
        int pick;
        if (burst_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      gap = 0;
            else if (pick < 85) gap = $urandom_range(1, 4);
            else                gap = $urandom_range(5, 40);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, line_no, chunk};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Waits until every due beat has arrived, then long enough for a clear
    // sweep (which causes no beat) to finish before the registers change.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cov_model.due_beats.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Writes both registers on back-to-back cycles.
    task automatic set_regs(input bit track, input t_chunk target);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TRACK;
        cfg_wdata <= 8'(track);
        cov_model.write_reg(CFG_TRACK, 8'(track));
        @(negedge clk);
        cfg_addr  <= CFG_TARGET;
        cfg_wdata <= target;
        cov_model.write_reg(CFG_TARGET, target);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random item. Most line events carry the tracked chunk and lines are
    // drawn mostly from a narrow window, so events, marks and reports meet on
    // the same lines. Repeats of the previous line exercise the skip of a
    // repeated event; zero and the top line show up now and then.
    task automatic random_item(input int mark_pct, input t_line base);
        t_cmd   cmd;
        t_chunk chunk;
        t_line  line_no;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)                 cmd = CMD_CLEAR;
        else if (pick < 9)            cmd = CMD_REPORT;
        else if (pick < 9 + mark_pct) cmd = CMD_MARK;
        else                          cmd = CMD_LINE;
        chunk = ($urandom_range(0, 9) < 8) ? cov_model.target : t_chunk'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3)       line_no = '0;
        else if (pick < 6)  line_no = '1;
        else if (pick < 16) line_no = recent_line;
        else if (pick < 40) line_no = t_line'($urandom);
        else                line_no = base + t_line'($urandom_range(0, 47));
        recent_line = line_no;
        offer_item(cmd, chunk, line_no);
    endtask

    // A random phase under one register setting, closed by a report so that
    // the last due beat comes after every item of the phase.
    task automatic random_phase(input bit track, input t_chunk target, input int count,
                                input int mark_pct);
        t_line base;
        settle();
        set_regs(track, target);
        base = t_line'($urandom_range(1, MAX_LINES - 49));
        repeat (count) random_item(mark_pct, base);
        offer_item(CMD_REPORT, target, '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        cov_model   = new;
        burst_left  = 0;
        recent_line = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // No target chunk: an event from chunk zero still matches and is
        // recorded, but the report is a lone all-zero summary.
        settle();
        set_regs(1'b1, 8'h00);
        offer_item(CMD_LINE,   8'h00, 12'd7);
        offer_item(CMD_MARK,   8'h00, 12'd7);
        offer_item(CMD_MARK,   8'hFF, 12'd4095);
        offer_item(CMD_REPORT, 8'h00, 12'd0);

        // Top chunk id. The line recorded under chunk zero is now visible.
        // Then a repeated line, line zero, a foreign chunk and a mark of
        // line zero, all of which leave the maps alone.
        settle();
        set_regs(1'b1, 8'hFF);
        offer_item(CMD_REPORT, 8'hFF, 12'd0);
        offer_item(CMD_LINE,   8'hFF, 12'd4095);
        offer_item(CMD_LINE,   8'hFF, 12'd4095);
        offer_item(CMD_LINE,   8'hFF, 12'd0);
        offer_item(CMD_LINE,   8'hFE, 12'd100);
        offer_item(CMD_MARK,   8'h00, 12'd100);
        offer_item(CMD_MARK,   8'h00, 12'd0);
        offer_item(CMD_MARK,   8'h00, 12'd1);
        offer_item(CMD_REPORT, 8'h00, 12'd0);
        // A clear keeps the last recorded line, so the same event right
        // after it is still skipped.
        offer_item(CMD_CLEAR,  8'h00, 12'd0);
        offer_item(CMD_MARK,   8'h00, 12'd4095);
        offer_item(CMD_LINE,   8'hFF, 12'd4095);
        offer_item(CMD_LINE,   8'hFF, 12'd1);
        offer_item(CMD_MARK,   8'h00, 12'd1);
        offer_item(CMD_REPORT, 8'h00, 12'd0);

        // Tracking off: events from the tracked chunk are dropped.
        settle();
        set_regs(1'b0, 8'hAA);
        offer_item(CMD_LINE,   8'hAA, 12'd4095);
        offer_item(CMD_MARK,   8'h00, 12'd2);
        offer_item(CMD_REPORT, 8'h00, 12'd0);

        // Random phases. The one with tracking off leans on marks, so its
        // reports run past the limit of listed uncovered lines.
        random_phase(1'b1, t_chunk'($urandom_range(1, 254)), 80, 40);
        random_phase(1'b0, t_chunk'($urandom_range(1, 254)), 70, 60);
        random_phase(1'b1, 8'h00, 50, 40);
        random_phase(1'b1, 8'hFF, 80, 40);
        random_phase(1'b1, 8'h01, 70, 45);
        random_phase(1'b1, t_chunk'($urandom_range(0, 255)), 70, 35);

        // Drain, then give the core time to show any stray beat.
        s_tvalid <= 1'b0;
        while (cov_model.due_beats.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);

        if (cov_model.failures == 0 && cov_model.due_beats.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lct_pkg.sv
rtl/lct_ram.sv
rtl/line_coverage_tracker_core.sv
tb/line_coverage_tracker_core_tb.sv
